FILE: rtl/utf8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants of the UTF-8 validating decoder
// Result layout, status codes, code point limits and queue sizing.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  // Field widths of one result item
  localparam int UNIT_W = 21;
  localparam int ST_W   = 3;
  localparam int OFF_W  = 32;

  // Status codes of a result item
  localparam logic [ST_W-1:0] ST_UNIT      = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_LEAD  = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_CONT  = 3'd2;
  localparam logic [ST_W-1:0] ST_OVERLONG  = 3'd3;
  localparam logic [ST_W-1:0] ST_SURROGATE = 3'd4;
  localparam logic [ST_W-1:0] ST_RANGE     = 3'd5;
  localparam logic [ST_W-1:0] ST_TRUNCATED = 3'd6;
  localparam logic [ST_W-1:0] ST_END_ONLY  = 3'd7;

  // Character lengths in bytes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // Code point limits and UTF-16 constants
  localparam logic [UNIT_W-1:0] MIN_LEN2     = 21'h000080;
  localparam logic [UNIT_W-1:0] MIN_LEN3     = 21'h000800;
  localparam logic [UNIT_W-1:0] SUPP_BASE    = 21'h010000;
  localparam logic [UNIT_W-1:0] SURR_HI_BASE = 21'h00D800;
  localparam logic [UNIT_W-1:0] SURR_LO_BASE = 21'h00DC00;
  localparam logic [UNIT_W-1:0] SURR_LAST    = 21'h00DFFF;
  localparam logic [UNIT_W-1:0] BMP_MAX      = 21'h00FFFF;
  localparam logic [UNIT_W-1:0] CP_MAX       = 21'h10FFFF;

  // Result queue sizing; one item makes at most two results
  localparam int FIFO_DEPTH    = 8;
  localparam int PTR_W         = 3;
  localparam int CNT_W         = 4;
  localparam int ROOM_PER_ITEM = 2;

  // One result item
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [ST_W-1:0]   status;
    logic [OFF_W-1:0]  offset;
    logic              last;
    logic              done;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/utf8d_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_step: per-byte decode step and string state
// Holds the character and string state and turns one byte into zero, one or
// two result items combinationally.
// ----------------------------------------------------------------------------
module utf8d_step
  import utf8d_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_vld,
  input  wire logic [7:0] item_byte,
  input  wire logic       item_eos,
  input  wire logic       mode,
  output logic [1:0]      res_n,
  output res_t            res0,
  output res_t            res1
);

  logic [2:0]             exp_r,  exp_nxt;
  logic [2:0]             seen_r, seen_nxt;
  logic [UNIT_W-1:0]      acc_r,  acc_nxt;
  logic [OFFSET_BITS-1:0] lead_r, lead_nxt;
  logic [OFFSET_BITS-1:0] pos_r,  pos_nxt;
  logic                   err_r,  err_nxt;

  function automatic logic [UNIT_W-1:0] min_for_len(input logic [2:0] len);
    logic [UNIT_W-1:0] m;
    unique case (len)
      LEN_2:   m = MIN_LEN2;
      LEN_3:   m = MIN_LEN3;
      LEN_4:   m = SUPP_BASE;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Decode one byte against the current state
  always_comb begin
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [UNIT_W-1:0]      acc_sh;
    logic [2:0]             seen_inc;
    logic                   fin;
    logic [UNIT_W-1:0]      fin_cp;
    logic [2:0]             fin_len;
    logic [ST_W-1:0]        fin_st;
    logic [UNIT_W-1:0]      supp;

    pos_inc  = pos_r + OFFSET_BITS'(1);
    acc_sh   = {acc_r[UNIT_W-7:0], item_byte[5:0]};
    seen_inc = seen_r + 3'd1;
    fin      = 1'b0;
    fin_cp   = '0;
    fin_len  = LEN_NONE;
    fin_st   = ST_UNIT;
    supp     = '0;

    exp_nxt  = exp_r;
    seen_nxt = seen_r;
    acc_nxt  = acc_r;
    lead_nxt = lead_r;
    pos_nxt  = pos_r;
    err_nxt  = err_r;
    res_n    = 2'd0;
    res0     = '0;
    res1     = '0;

    if (item_vld) begin
      // Advance character state
      if (err_r) begin
        if (item_eos) begin
          res0.status = ST_END_ONLY;
          res_n       = 2'd1;
        end
      end else if (exp_r == LEN_NONE) begin
        lead_nxt = pos_r;
        seen_nxt = 3'd1;
        if (item_byte[7] == 1'b0) begin
          fin     = 1'b1;
          fin_cp  = UNIT_W'(item_byte);
          fin_len = LEN_1;
        end else if (item_byte[7:5] == 3'b110) begin
          exp_nxt = LEN_2;
          acc_nxt = UNIT_W'(item_byte[4:0]);
        end else if (item_byte[7:4] == 4'b1110) begin
          exp_nxt = LEN_3;
          acc_nxt = UNIT_W'(item_byte[3:0]);
        end else if (item_byte[7:3] == 5'b11110) begin
          exp_nxt = LEN_4;
          acc_nxt = UNIT_W'(item_byte[2:0]);
        end else begin
          seen_nxt    = 3'd0;
          err_nxt     = 1'b1;
          res0.status = ST_BAD_LEAD;
          res0.offset = OFF_W'(pos_r);
          res_n       = 2'd1;
        end
      end else if (item_byte[7:6] != 2'b10) begin
        exp_nxt     = LEN_NONE;
        seen_nxt    = 3'd0;
        acc_nxt     = '0;
        err_nxt     = 1'b1;
        res0.status = ST_BAD_CONT;
        res0.offset = OFF_W'(pos_r);
        res_n       = 2'd1;
      end else begin
        acc_nxt  = acc_sh;
        seen_nxt = seen_inc;
        if (seen_inc >= exp_r) begin
          fin     = 1'b1;
          fin_cp  = acc_sh;
          fin_len = exp_r;
        end
      end

      // Check and emit a completed character
      if (fin) begin
        if (fin_cp < min_for_len(fin_len)) begin
          fin_st = ST_OVERLONG;
        end else if (fin_len == LEN_3 && fin_cp >= SURR_HI_BASE && fin_cp <= SURR_LAST) begin
          fin_st = ST_SURROGATE;
        end else if (fin_cp > CP_MAX) begin
          fin_st = ST_RANGE;
        end
        exp_nxt  = LEN_NONE;
        seen_nxt = 3'd0;
        acc_nxt  = '0;
        supp     = fin_cp - SUPP_BASE;
        if (fin_st != ST_UNIT) begin
          err_nxt     = 1'b1;
          res0.status = fin_st;
          res0.offset = OFF_W'(lead_r);
          res_n       = 2'd1;
        end else if (mode && fin_cp > BMP_MAX) begin
          res0.unit = SURR_HI_BASE + UNIT_W'(supp[19:10]);
          res1.unit = SURR_LO_BASE + UNIT_W'(supp[9:0]);
          res_n     = 2'd2;
        end else begin
          res0.unit = fin_cp;
          res_n     = 2'd1;
        end
      end

      // Report a string that ends inside a character
      if (item_eos && res_n == 2'd0) begin
        res0.status = ST_TRUNCATED;
        res0.offset = OFF_W'(pos_inc);
        res_n       = 2'd1;
      end

      // Mark the final result of this byte and of the string
      if (res_n == 2'd2) begin
        res1.last = 1'b1;
        res1.done = item_eos;
      end else begin
        res0.last = 1'b1;
        res0.done = item_eos;
      end

      // Restart at the end of the string, else advance the position
      if (item_eos) begin
        exp_nxt  = LEN_NONE;
        seen_nxt = 3'd0;
        acc_nxt  = '0;
        lead_nxt = '0;
        pos_nxt  = '0;
        err_nxt  = 1'b0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= LEN_NONE;
      seen_r <= 3'd0;
      acc_r  <= '0;
      lead_r <= '0;
      pos_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      exp_r  <= exp_nxt;
      seen_r <= seen_nxt;
      acc_r  <= acc_nxt;
      lead_r <= lead_nxt;
      pos_r  <= pos_nxt;
      err_r  <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (exp_r == LEN_NONE))
    else $error("character in flight after an error");

  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r != LEN_NONE) |-> (seen_r != 3'd0 && seen_r < exp_r))
    else $error("byte count outside the character length");

  a_pair_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (res_n == 2'd2) |-> (mode && res0.status == ST_UNIT && res1.status == ST_UNIT))
    else $error("surrogate pair outside UTF-16 mode");
`endif

endmodule
`default_nettype wire

FILE: rtl/utf8d_res_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_res_fifo: result queue
// Takes up to two result items per cycle and hands out one per cycle while
// out_stall is low, on a valid/stall channel.
// ----------------------------------------------------------------------------
module utf8d_res_fifo
  import utf8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  wr_n,
  input  wire res_t        wr0,
  input  wire res_t        wr1,
  input  wire logic        out_stall,
  output logic             out_valid,
  output res_t             head,
  output logic [CNT_W-1:0] count
);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             rd;

  assign out_valid = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign count     = count_r;
  assign rd        = out_valid && !out_stall;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(wr_n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(rd);
    count_nxt  = count_r + CNT_W'(wr_n) - CNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store incoming result items
  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem[wr_ptr_r] <= wr0;
    end
    if (wr_n == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= wr1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r + CNT_W'(wr_n)) <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0])
    else $error("queue pointers disagree with occupancy");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (count_r == '0))
    else $error("queue not empty after reset");
`endif

endmodule
`default_nettype wire

FILE: rtl/utf8_validating_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_validating_decoder_core: streaming UTF-8 validator and decoder
// Bytes of a string enter one per item; results leave as code points or
// UTF-16 code units, with at most one error report per string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one byte per item, in_end_of_string on the last
//   byte of a string. An item is taken when in_valid is high and in_stall
//   is low. Output channel out_*: zero, one or two result items per byte,
//   taken when out_valid is high and out_stall is low.
//   A byte taken on in_* is registered, decoded and its results written
//   to the queue that drives out_*. Throughput: one byte per cycle while
//   in_stall is low; the two units of a surrogate pair leave one at a time
//   through the single result port.
//   Results wait in an 8-entry queue; in_stall rises when the queue cannot
//   hold the results of the byte in flight plus two more, so a stalled
//   receiver backs up the input after a few items and nothing is lost.
//   cfg_wr_en/cfg_wr_data set the output mode (0 UTF-32, 1 UTF-16); write
//   it only while the block is idle.
//   Reset (rst_n low, synchronous) empties the queue, clears the string
//   state and selects UTF-32; no item is taken during reset.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_core
  import utf8d_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_end_of_string,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [UNIT_W-1:0]      out_unit,
  output logic [ST_W-1:0]        out_status,
  output logic [OFF_W-1:0]       out_error_offset,
  output logic                   out_last_of_run,
  output logic                   out_string_done
);

  logic             mode_r, mode_nxt;
  logic             in_vld_r, in_vld_nxt;
  logic [7:0]       in_byte_r;
  logic             in_eos_r;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W-1:0] q_free;
  logic [1:0]       res_n;
  res_t             res0;
  res_t             res1;
  res_t             head;

  // Hold input while the queue lacks room for the byte in flight and this one
  assign q_free   = CNT_W'(FIFO_DEPTH) - q_count;
  assign in_stall = !rst_n ||
                    (in_vld_r ? (q_free < CNT_W'(2 * ROOM_PER_ITEM))
                              : (q_free < CNT_W'(ROOM_PER_ITEM)));

  always_comb begin
    in_vld_nxt = in_valid && !in_stall;
    mode_nxt   = cfg_wr_en ? cfg_wr_data : mode_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      in_vld_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      in_vld_r <= in_vld_nxt;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (in_vld_nxt) begin
      in_byte_r <= in_data_byte;
      in_eos_r  <= in_end_of_string;
    end
  end

  utf8d_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_vld_r),
    .item_byte (in_byte_r),
    .item_eos  (in_eos_r),
    .mode      (mode_r),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  utf8d_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_n      (res_n),
    .wr0       (res0),
    .wr1       (res1),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_unit         = head.unit;
  assign out_status       = head.status;
  assign out_error_offset = head.offset;
  assign out_last_of_run  = head.last;
  assign out_string_done  = head.done;

endmodule
`default_nettype wire
